>>> rtl/taes_pkg.sv
// shared types, constants and round functions for the tweakable aes-128 cipher
`timescale 1ns / 1ps
package taes_pkg;

	localparam int NUM_ROUNDS   = 10;
	localparam int TWEAK_PERIOD = 2;
	localparam int NUM_CELLS    = NUM_ROUNDS + 1;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_index_t;

	typedef enum logic {
		ACT_ENCRYPT = 1'b0,
		ACT_DECRYPT = 1'b1
	} action_t;

	typedef logic [127:0] block_t;
	typedef logic [7:0]   byte_t;

	// item travelling down the cell chain
	typedef struct packed {
		logic   valid;
		logic   action;
		byte_t  tweak_byte;
		block_t state;
	} cell_data_t;

	localparam byte_t RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
		8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

	localparam byte_t FWD_SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// state byte i sits at bits 127-8i .. 120-8i
	function automatic byte_t get_byte(block_t b, int i);
		return b[127 - 8 * i -: 8];
	endfunction

	function automatic byte_t xtime(byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic block_t byte_subst(block_t s, logic inv);
		block_t r;
		for (int i = 0; i < 16; i++) begin
			r[127 - 8 * i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : FWD_SBOX[get_byte(s, i)];
		end
		return r;
	endfunction

	function automatic block_t row_shift(block_t s, logic inv);
		block_t r;
		for (int rw = 0; rw < 4; rw++) begin
			for (int c = 0; c < 4; c++) begin
				if (inv) begin
					r[127 - 8 * (rw + 4 * ((c + rw) % 4)) -: 8] = get_byte(s, rw + 4 * c);
				end else begin
					r[127 - 8 * (rw + 4 * c) -: 8] = get_byte(s, rw + 4 * ((c + rw) % 4));
				end
			end
		end
		return r;
	endfunction

	function automatic block_t column_mix(block_t s, logic inv);
		block_t r;
		byte_t a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, u, v;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4 * c);
			a1 = get_byte(s, 4 * c + 1);
			a2 = get_byte(s, 4 * c + 2);
			a3 = get_byte(s, 4 * c + 3);
			// inverse: premultiply by (5,0,4,0) then forward mix
			if (inv) begin
				u = xtime(xtime(a0 ^ a2));
				v = xtime(xtime(a1 ^ a3));
				a0 = a0 ^ u;
				a1 = a1 ^ v;
				a2 = a2 ^ u;
				a3 = a3 ^ v;
			end
			x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
			y0 = x0 ^ x1 ^ a1 ^ a2 ^ a3;
			y1 = a0 ^ x1 ^ x2 ^ a2 ^ a3;
			y2 = a0 ^ a1 ^ x2 ^ x3 ^ a3;
			y3 = x0 ^ a0 ^ a1 ^ a2 ^ x3;
			r[127 - 32 * c -: 32] = {y0, y1, y2, y3};
		end
		return r;
	endfunction

	// bit j of e into bit 0 of byte j
	function automatic block_t add_tweak(block_t s, byte_t e);
		block_t r;
		r = s;
		for (int j = 0; j < 8; j++) begin
			r[120 - 8 * j] = s[120 - 8 * j] ^ e[j];
		end
		return r;
	endfunction

	function automatic block_t next_round_key(block_t k, byte_t rc);
		block_t n;
		logic [31:0] t;
		t = {FWD_SBOX[get_byte(k, 13)] ^ rc, FWD_SBOX[get_byte(k, 14)],
			FWD_SBOX[get_byte(k, 15)], FWD_SBOX[get_byte(k, 12)]};
		n[127:96] = k[127:96] ^ t;
		n[95:64]  = k[95:64] ^ n[127:96];
		n[63:32]  = k[63:32] ^ n[95:64];
		n[31:0]   = k[31:0] ^ n[63:32];
		return n;
	endfunction

	function automatic byte_t spread_tweak(logic [3:0] t);
		return {t ^ {4{^t}}, t};
	endfunction

endpackage

>>> rtl/taes_key_cell.sv
// one step of the key schedule: holds one round key, recomputed from its neighbour
`timescale 1ns / 1ps
module taes_key_cell import taes_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  byte_t  rcon,
	input  block_t prev_key,
	output block_t round_key
);

	block_t key_q;

	// resets to the schedule of the all-zero key one cell per cycle after release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else begin
			key_q <= next_round_key(prev_key, rcon);
		end
	end

	assign round_key = key_q;

endmodule

>>> rtl/taes_round_cell.sv
// one cipher round cell: serves encryption round r and decryption round 11-r
`timescale 1ns / 1ps
module taes_round_cell import taes_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [3:0] enc_round,
	input  block_t     enc_key,
	input  block_t     dec_key,
	input  cell_data_t prev,
	output cell_data_t next
);

	logic [3:0] dec_round;
	logic       last_enc;
	logic       enc_tweak;
	logic       dec_tweak;
	block_t     e_st;
	block_t     d_st;
	logic       valid_q;
	logic       action_q;
	byte_t      tweak_q;
	block_t     state_q;

	// decryption cell k undoes encryption round 11-k:
	// tweak(11-k), key(11-k) and inv mix (both skipped in first cell), inv shift, inv sub
	assign dec_round = 4'(NUM_ROUNDS + 1) - enc_round;
	assign last_enc  = (enc_round == 4'(NUM_ROUNDS));
	assign enc_tweak = !last_enc && ((32'(enc_round) % TWEAK_PERIOD) == 0);
	assign dec_tweak = (enc_round != 4'd1) && ((32'(dec_round) % TWEAK_PERIOD) == 0);

	always_comb begin
		e_st = row_shift(byte_subst(prev.state, 1'b0), 1'b0);
		if (!last_enc) begin
			e_st = column_mix(e_st, 1'b0);
		end
		e_st = e_st ^ enc_key;
		if (enc_tweak) begin
			e_st = add_tweak(e_st, prev.tweak_byte);
		end

		d_st = prev.state;
		if (dec_tweak) begin
			d_st = add_tweak(d_st, prev.tweak_byte);
		end
		if (enc_round != 4'd1) begin
			d_st = column_mix(d_st ^ dec_key, 1'b1);
		end
		d_st = byte_subst(row_shift(d_st, 1'b1), 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= prev.action;
			tweak_q  <= prev.tweak_byte;
			state_q  <= (prev.action == ACT_DECRYPT) ? d_st : e_st;
		end
	end

	assign next = {valid_q, action_q, tweak_q, state_q};

endmodule

>>> rtl/tweakable_aes128_block_cipher.sv
// tweakable aes-128 top level: key schedule chain, round cell chain and output skid
`timescale 1ns / 1ps
// a block passes the entry key add stage, 10 round cells and the output register in order
// throughput: one block per cycle; the whole chain stalls only while a result waits at the output
// round keys live in a chain of 10 key cells fed from the key registers; after a key
// write, input is held off (tready low) until the new key has reached the last key cell
// reset clears key registers to zero, empties the pipeline and holds input off until keys settle
module tweakable_aes128_block_cipher import taes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// from bit 0: block_in_high, block_in_low, tweak, zero fill
	input  logic [135:0] s_axis_tdata,
	// action
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// block_out_high [63:0], block_out_low [127:64]
	output logic [127:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_wdata
);

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [3:0]  settle_q;
	block_t      rk [NUM_CELLS];
	cell_data_t  chain [NUM_CELLS];
	logic        advance;
	block_t      in_block;
	logic [3:0]  in_tweak;
	logic        in_valid_s1;
	logic        in_action_s1;
	byte_t       in_tweak_s1;
	block_t      in_state_s1;
	logic        out_valid_q;
	block_t      out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_wdata;
				REG_KEY_LOW:  key_low_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input held off until the new key has reached the last key cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 4'(NUM_ROUNDS);
		end else if (cfg_we) begin
			settle_q <= 4'(NUM_ROUNDS);
		end else if (settle_q != 4'd0) begin
			settle_q <= settle_q - 4'd1;
		end
	end

	assign rk[0] = {key_high_q, key_low_q};

	for (genvar g = 1; g < NUM_CELLS; g++) begin : g_key
		taes_key_cell u_key (
			.clk      (clk),
			.arst_n   (arst_n),
			.rcon     (RCON[g - 1]),
			.prev_key (rk[g - 1]),
			.round_key(rk[g])
		);
	end

	// chain moves when the output register is empty or drains
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = advance && (settle_q == 4'd0);

	assign in_block = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
	assign in_tweak = s_axis_tdata[131:128];

	// entry stage: first key add (key 0 encrypt, key 10 decrypt)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (advance) begin
			in_valid_s1 <= s_axis_tvalid && (settle_q == 4'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			in_action_s1 <= s_axis_tuser;
			in_tweak_s1  <= spread_tweak(in_tweak);
			in_state_s1  <= in_block ^
				((s_axis_tuser == ACT_DECRYPT) ? rk[NUM_ROUNDS] : rk[0]);
		end
	end

	assign chain[0] = {in_valid_s1, in_action_s1, in_tweak_s1, in_state_s1};

	for (genvar g = 1; g < NUM_CELLS; g++) begin : g_round
		taes_round_cell u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.enc_round(4'(g)),
			.enc_key  (rk[g]),
			.dec_key  (rk[NUM_ROUNDS + 1 - g]),
			.prev     (chain[g - 1]),
			.next     (chain[g])
		);
	end

	// last cell leaves decryption one key add short: key 0 goes in here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= chain[NUM_ROUNDS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= chain[NUM_ROUNDS].state ^
				((chain[NUM_ROUNDS].action == ACT_DECRYPT) ? rk[0] : '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q[63:0], out_q[127:64]};

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && (settle_q == 4'd0) |-> s_axis_tready)
		else $error("input stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		advance && chain[NUM_ROUNDS].valid |=> m_axis_tvalid)
		else $error("result lost at output");
`endif

endmodule
